>>> sv/ste_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_pkg: shared types and constants of the sorted triple adjacency encoder
// Word width, output slot codes and the queue entry that links the front
// classifier to the back serializer.
// ----------------------------------------------------------------------------
package ste_pkg;

	localparam int WORD_W = 32;
	localparam int SLOT_N = 6;

	// Slot positions of the fixed word template of one triple:
	// Y 0, Z 0, Y predicate, Z object, Y 0, Z 0
	localparam int SLOT_YSEP_HEAD = 0;
	localparam int SLOT_ZSEP_HEAD = 1;
	localparam int SLOT_PRED      = 2;
	localparam int SLOT_OBJ       = 3;
	localparam int SLOT_YSEP_TAIL = 4;
	localparam int SLOT_ZSEP_TAIL = 5;

	typedef logic [SLOT_N-1:0] slot_mask_t;

	// Slots that go to the Z object stream
	localparam slot_mask_t Z_SLOTS = 6'b101010;

	localparam logic STREAM_Y = 1'b0;
	localparam logic STREAM_Z = 1'b1;

	// One classified triple waiting for serialization
	typedef struct packed {
		slot_mask_t        mask;
		logic [WORD_W-1:0] pred;
		logic [WORD_W-1:0] obj;
		logic [WORD_W-1:0] count;
	} ste_entry_t;

endpackage

>>> sv/ste_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_front: triple classifier
// Accepts one triple a cycle while the queue is not full, compares it with
// the last kept triple, picks the words it causes as a slot mask, keeps the
// distinct count and pushes the result into the queue.
// ----------------------------------------------------------------------------
module ste_front #(
	parameter int ID_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          triple_valid,
	output logic                          triple_stall,
	input  logic [ste_pkg::WORD_W-1:0]    subject_id,
	input  logic [ste_pkg::WORD_W-1:0]    predicate_id,
	input  logic [ste_pkg::WORD_W-1:0]    object_id,
	input  logic                          last_triple,
	output logic                          push,
	output ste_pkg::ste_entry_t           push_entry,
	input  logic                          full
);
	import ste_pkg::*;

	localparam int IdW = (ID_BITS < WORD_W) ? ID_BITS : WORD_W;

	logic [IdW-1:0]    subj, pred, obj;
	logic [IdW-1:0]    prev_subj_q, prev_pred_q, prev_obj_q;
	logic [IdW-1:0]    subj_nxt, pred_nxt, obj_nxt;
	logic              started_q;
	logic [WORD_W-1:0] total_q, total_nxt;
	logic              count_inc;
	slot_mask_t        mask;
	logic              accept;

	// Keep only the low ID bits
	assign subj = subject_id[IdW-1:0];
	assign pred = predicate_id[IdW-1:0];
	assign obj  = object_id[IdW-1:0];

	assign accept       = triple_valid && !full;
	assign triple_stall = full;

	// Classify the beat against the last kept triple
	always_comb begin
		mask      = '0;
		count_inc = 1'b0;
		subj_nxt  = prev_subj_q;
		pred_nxt  = prev_pred_q;
		obj_nxt   = prev_obj_q;
		if (!started_q) begin
			// first triple of a stream: cleared object means zero object is a repeat
			mask[SLOT_PRED] = 1'b1;
			mask[SLOT_OBJ]  = (obj != '0);
			count_inc       = (obj != '0);
			subj_nxt        = subj;
			pred_nxt        = pred;
			obj_nxt         = obj;
		end else if (subj == prev_subj_q && pred == prev_pred_q) begin
			if (obj != prev_obj_q) begin
				mask[SLOT_OBJ] = 1'b1;
				count_inc      = 1'b1;
				obj_nxt        = obj;
			end
		end else if (subj == prev_subj_q) begin
			mask[SLOT_ZSEP_HEAD] = 1'b1;
			mask[SLOT_PRED]      = 1'b1;
			mask[SLOT_OBJ]       = 1'b1;
			count_inc            = 1'b1;
			pred_nxt             = pred;
			obj_nxt              = obj;
		end else begin
			mask[SLOT_YSEP_HEAD] = 1'b1;
			mask[SLOT_ZSEP_HEAD] = 1'b1;
			mask[SLOT_PRED]      = 1'b1;
			mask[SLOT_OBJ]       = 1'b1;
			count_inc            = 1'b1;
			subj_nxt             = subj;
			pred_nxt             = pred;
			obj_nxt              = obj;
		end
		if (last_triple) begin
			mask[SLOT_YSEP_TAIL] = 1'b1;
			mask[SLOT_ZSEP_TAIL] = 1'b1;
		end
	end

	// Saturating distinct count
	assign total_nxt = (count_inc && total_q != '1) ? total_q + 1'b1 : total_q;

	// Build the queue entry; drop beats that cause no word
	assign push             = accept && (mask != '0);
	assign push_entry.mask  = mask;
	assign push_entry.pred  = WORD_W'(pred);
	assign push_entry.obj   = WORD_W'(obj);
	assign push_entry.count = total_nxt;

	// Hold the last kept triple; clear it after the closing triple
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_subj_q <= '0;
			prev_pred_q <= '0;
			prev_obj_q  <= '0;
			started_q   <= 1'b0;
			total_q     <= '0;
		end else if (accept) begin
			if (last_triple) begin
				prev_subj_q <= '0;
				prev_pred_q <= '0;
				prev_obj_q  <= '0;
				started_q   <= 1'b0;
				total_q     <= '0;
			end else begin
				prev_subj_q <= subj_nxt;
				prev_pred_q <= pred_nxt;
				prev_obj_q  <= obj_nxt;
				started_q   <= 1'b1;
				total_q     <= total_nxt;
			end
		end
	end

endmodule

>>> sv/ste_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_queue: classified triple queue
// Small register queue that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module ste_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ste_pkg::ste_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output ste_pkg::ste_entry_t head,
	output logic                empty
);
	import ste_pkg::*;

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	ste_entry_t      entries_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entries_q[rd_ptr_q];

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/ste_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_back: word serializer
// Walks the slot mask of the head entry lowest slot first and sends one word
// a beat through an output register while word_stall is low.
// ----------------------------------------------------------------------------
module ste_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ste_pkg::ste_entry_t        head,
	input  logic                       empty,
	output logic                       pop,
	output logic                       word_valid,
	input  logic                       word_stall,
	output logic                       stream_select,
	output logic [ste_pkg::WORD_W-1:0] word,
	output logic                       last_word,
	output logic [ste_pkg::WORD_W-1:0] distinct_count
);
	import ste_pkg::*;

	slot_mask_t        done_q;
	slot_mask_t        remaining, pick, rest;
	logic              load;
	logic              word_valid_q;
	logic              stream_select_q;
	logic [WORD_W-1:0] word_q;
	logic              last_word_q;
	logic [WORD_W-1:0] count_q;

	// Pick the lowest slot not yet sent
	assign remaining = head.mask & ~done_q;
	assign pick      = remaining & (~remaining + 1'b1);
	assign rest      = remaining & ~pick;
	assign load      = !empty && (!word_valid_q || !word_stall);
	assign pop       = load && (rest == '0);

	// Track sent slots of the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (load) begin
			done_q <= (rest == '0) ? '0 : (done_q | pick);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else if (!word_valid_q || !word_stall) begin
			word_valid_q <= !empty;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			stream_select_q <= (|(pick & Z_SLOTS)) ? STREAM_Z : STREAM_Y;
			word_q          <= pick[SLOT_PRED] ? head.pred :
			                   pick[SLOT_OBJ]  ? head.obj  : '0;
			last_word_q     <= (rest == '0);
			count_q         <= head.count;
		end
	end

	assign word_valid     = word_valid_q;
	assign stream_select  = stream_select_q;
	assign word           = word_q;
	assign last_word      = last_word_q;
	assign distinct_count = count_q;

endmodule

>>> sv/sorted_triple_adjacency_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_triple_adjacency_encoder: sorted triples to Y/Z adjacency words
// Encodes sorted (subject, predicate, object) triples as a predicate stream
// and an object stream with 0 as list separator.
// ----------------------------------------------------------------------------
// Usage:
//   Triples enter on triple_valid/triple_stall, one beat per triple; mark the
//   final triple with last_triple to get the closing separators and restart
//   the stream. Words leave on word_valid/word_stall, one word a beat, with
//   stream_select naming the stream, last_word on the final word of a triple
//   and distinct_count the running number of distinct triples.
//   A triple is classified in the beat it is accepted and queued; its first
//   word reaches the output register from the queue. The front takes one
//   triple a cycle while the queue has room; the output register sends one
//   word a cycle while word_stall is low. Repeats cause no word unless they
//   close the stream. The serializer output register sets the sustained rate.
//   Reset clears the kept triple, the count and the queue. While word_stall
//   is high the output beat holds and the queue fills; with QUEUE_DEPTH
//   entries waiting triple_stall rises.
// ----------------------------------------------------------------------------
module sorted_triple_adjacency_encoder #(
	parameter int ID_BITS     = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       triple_valid,
	output logic                       triple_stall,
	input  logic [ste_pkg::WORD_W-1:0] subject_id,
	input  logic [ste_pkg::WORD_W-1:0] predicate_id,
	input  logic [ste_pkg::WORD_W-1:0] object_id,
	input  logic                       last_triple,
	output logic                       word_valid,
	input  logic                       word_stall,
	output logic                       stream_select,
	output logic [ste_pkg::WORD_W-1:0] word,
	output logic                       last_word,
	output logic [ste_pkg::WORD_W-1:0] distinct_count
);
	import ste_pkg::*;

	ste_entry_t push_entry, head;
	logic       push, full, pop, empty;

	// Classify triples
	ste_front #(
		.ID_BITS (ID_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.triple_valid (triple_valid),
		.triple_stall (triple_stall),
		.subject_id   (subject_id),
		.predicate_id (predicate_id),
		.object_id    (object_id),
		.last_triple  (last_triple),
		.push         (push),
		.push_entry   (push_entry),
		.full         (full)
	);

	// Decouple front and back
	ste_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	// Serialize words
	ste_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (empty),
		.pop            (pop),
		.word_valid     (word_valid),
		.word_stall     (word_stall),
		.stream_select  (stream_select),
		.word           (word),
		.last_word      (last_word),
		.distinct_count (distinct_count)
	);

endmodule

>>> sv/ste_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_checker: port checks of the sorted triple adjacency encoder
// Watches the top level ports over time; attached by a bind statement.
// ----------------------------------------------------------------------------
module ste_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       triple_stall,
	input logic                       word_valid,
	input logic                       word_stall,
	input logic                       stream_select,
	input logic [ste_pkg::WORD_W-1:0] word,
	input logic                       last_word,
	input logic [ste_pkg::WORD_W-1:0] distinct_count
);
	import ste_pkg::*;

	// Hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_stall |=> word_valid && $stable(word) &&
		$stable(stream_select) && $stable(last_word) && $stable(distinct_count))
		else $error("stalled output beat changed");

	// Send the words of one triple back to back, all with the same count
	a_words_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_stall && !last_word |=> word_valid && $stable(distinct_count))
		else $error("gap or count change inside one triple");

	// An empty output register means the queue has room
	a_room_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!word_valid |-> !triple_stall)
		else $error("input stalled while output idle");

	// Show no beat during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !word_valid && !triple_stall)
		else $error("activity during reset");

endmodule

bind sorted_triple_adjacency_encoder ste_checker u_ste_checker (.*);

>>> test/ste_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_stream_checker: word stream predictor and checker for the encoder
// Watches the triple and word channels of the sorted triple adjacency
// encoder. Encodes every accepted triple into the Y/Z words it must cause,
// queues them, and compares each accepted word field by field in order.
// ----------------------------------------------------------------------------
module ste_stream_checker
	import ste_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              triple_valid,
	input  logic              triple_stall,
	input  logic [WORD_W-1:0] subject_id,
	input  logic [WORD_W-1:0] predicate_id,
	input  logic [WORD_W-1:0] object_id,
	input  logic              last_triple,
	input  logic              word_valid,
	input  logic              word_stall,
	input  logic              stream_select,
	input  logic [WORD_W-1:0] word,
	input  logic              last_word,
	input  logic [WORD_W-1:0] distinct_count,
	output int                error_count,
	output int                words_pending
);

	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic              sel;
		logic [WORD_W-1:0] value;
		logic              closes;
		logic [WORD_W-1:0] tally;
	} enc_word_t;

	// Last kept triple and running count of the open stream
	logic [WORD_W-1:0] kept_subject;
	logic [WORD_W-1:0] kept_predicate;
	logic [WORD_W-1:0] kept_object;
	logic [WORD_W-1:0] distinct_tally;
	logic              stream_open;

	enc_word_t expected_words[$];
	enc_word_t triple_words[$];

	task automatic clear_stream();
		kept_subject = '0;
		kept_predicate = '0;
		kept_object = '0;
		distinct_tally = '0;
		stream_open = 1'b0;
	endtask

	task automatic add_word(input logic sel, input logic [WORD_W-1:0] value);
		enc_word_t w;
		w.sel = sel;
		w.value = value;
		w.closes = 1'b0;
		w.tally = '0;
		triple_words.push_back(w);
	endtask

	// Encode one triple into its words and queue them
	task automatic encode_triple(input logic [WORD_W-1:0] s, p, o, input logic fin);
		triple_words.delete();
		// open a stream: the first predicate goes out, the object compares to zero
		if (!stream_open) begin
			stream_open = 1'b1;
			kept_subject = s;
			kept_predicate = p;
			kept_object = '0;
			add_word(STREAM_Y, p);
		end
		if (s != kept_subject) begin
			add_word(STREAM_Y, '0);
			add_word(STREAM_Z, '0);
			kept_subject = s;
			kept_predicate = p;
			kept_object = o;
			add_word(STREAM_Y, p);
			add_word(STREAM_Z, o);
			if (~&distinct_tally) distinct_tally = distinct_tally + 1'b1;
		end else if (p != kept_predicate) begin
			add_word(STREAM_Z, '0);
			kept_predicate = p;
			kept_object = o;
			add_word(STREAM_Y, p);
			add_word(STREAM_Z, o);
			if (~&distinct_tally) distinct_tally = distinct_tally + 1'b1;
		end else if (o != kept_object) begin
			kept_object = o;
			add_word(STREAM_Z, o);
			if (~&distinct_tally) distinct_tally = distinct_tally + 1'b1;
		end
		// close both lists on the final triple
		if (fin) begin
			add_word(STREAM_Y, '0);
			add_word(STREAM_Z, '0);
		end
		foreach (triple_words[i]) triple_words[i].tally = distinct_tally;
		if (triple_words.size() > 0) triple_words[triple_words.size()-1].closes = 1'b1;
		foreach (triple_words[i]) expected_words.push_back(triple_words[i]);
		if (fin) clear_stream();
	endtask

	// Predict on triple beats, compare on word beats
	always @(posedge clk or negedge arst_n) begin
		enc_word_t want;
		if (!arst_n) begin
			clear_stream();
			expected_words.delete();
			error_count = 0;
		end else begin
			if (triple_valid && !triple_stall)
				encode_triple(subject_id, predicate_id, object_id, last_triple);
			if (word_valid && !word_stall) begin
				if (expected_words.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: unexpected word beat: sel=%0b word=%h last=%0b count=%0d",
							$realtime, stream_select, word, last_word, distinct_count);
				end else begin
					want = expected_words.pop_front();
					if (stream_select !== want.sel || word !== want.value ||
							last_word !== want.closes || distinct_count !== want.tally) begin
						error_count++;
						if (error_count <= REPORT_LIMIT)
							$display({"%0t: word mismatch: expected sel=%0b word=%h last=%0b count=%0d,",
								" got sel=%0b word=%h last=%0b count=%0d"}, $realtime,
								want.sel, want.value, want.closes, want.tally,
								stream_select, word, last_word, distinct_count);
					end
				end
			end
		end
		words_pending = expected_words.size();
	end

endmodule

>>> test/sorted_triple_adjacency_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_triple_adjacency_encoder_tb: regression of the triple encoder
// Drives directed and random triple streams with random gaps and output
// stalls, including a long output hold-off and a full drain, and reports the
// verdict from the stream checker's error count.
// ----------------------------------------------------------------------------
module sorted_triple_adjacency_encoder_tb;
	import ste_pkg::*;

	localparam int TOTAL_ITEMS = 370;
	localparam int LONG_HOLD   = 60;
	localparam int CYCLE_LIMIT = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b1;
	logic              triple_valid = 1'b0;
	logic              triple_stall;
	logic [WORD_W-1:0] subject_id = '0;
	logic [WORD_W-1:0] predicate_id = '0;
	logic [WORD_W-1:0] object_id = '0;
	logic              last_triple = 1'b0;
	logic              word_valid;
	logic              word_stall = 1'b0;
	logic              stream_select;
	logic [WORD_W-1:0] word;
	logic              last_word;
	logic [WORD_W-1:0] distinct_count;

	int error_count;
	int words_pending;
	int cycle_count = 0;
	int triples_sent = 0;
	int stall_left = 0;
	int hold_requests = 0;
	int hold_served = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	always #5 clk = ~clk;

	sorted_triple_adjacency_encoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.triple_valid   (triple_valid),
		.triple_stall   (triple_stall),
		.subject_id     (subject_id),
		.predicate_id   (predicate_id),
		.object_id      (object_id),
		.last_triple    (last_triple),
		.word_valid     (word_valid),
		.word_stall     (word_stall),
		.stream_select  (stream_select),
		.word           (word),
		.last_word      (last_word),
		.distinct_count (distinct_count)
	);

	ste_stream_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.triple_valid   (triple_valid),
		.triple_stall   (triple_stall),
		.subject_id     (subject_id),
		.predicate_id   (predicate_id),
		.object_id      (object_id),
		.last_triple    (last_triple),
		.word_valid     (word_valid),
		.word_stall     (word_stall),
		.stream_select  (stream_select),
		.word           (word),
		.last_word      (last_word),
		.distinct_count (distinct_count),
		.error_count    (error_count),
		.words_pending  (words_pending)
	);

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sorted_triple_adjacency_encoder regression: fail");
			$finish;
		end
	end

	// Stall the word channel: mostly short stalls, a few long, quiet stretches,
	// and a long hold-off whenever the stimulus asks for one
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			stall_left <= LONG_HOLD;
			word_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			word_stall <= 1'b1;
		end else if (rx_quiet || $urandom_range(0, 99) < 70) begin
			word_stall <= 1'b0;
		end else begin
			word_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
		end
	end

	// Offer one triple after a random gap and hold it until its beat
	task automatic send_triple(input logic [WORD_W-1:0] s, p, o, input logic fin);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 60) gap = 0;
		else if (r < 92) gap = $urandom_range(1, 3);
		else gap = $urandom_range(8, 25);
		if (gap > 0) begin
			@(negedge clk);
			triple_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		triple_valid <= 1'b1;
		subject_id <= s;
		predicate_id <= p;
		object_id <= o;
		last_triple <= fin;
		do @(posedge clk); while (triple_stall);
		triples_sent++;
	endtask

	// Send one mostly sorted stream with random IDs, closed by its last triple
	task automatic run_random_stream(input int len);
		logic [WORD_W-1:0] s;
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] o;
		int r;
		s = $urandom;
		p = $urandom;
		o = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
		for (int i = 0; i < len; i++) begin
			if (i > 0) begin
				r = $urandom_range(0, 99);
				if (r < 35) begin
					o = o + $urandom_range(1, 500);
				end else if (r < 55) begin
					p = p + $urandom_range(1, 50);
					o = $urandom;
				end else if (r < 75) begin
					s = s + $urandom_range(1, 50);
					p = $urandom;
					o = $urandom;
				end else if (r < 85) begin
					// unsorted jump with small, possibly zero, object
					s = $urandom;
					p = $urandom_range(0, 3);
					o = $urandom_range(0, 3);
				end
				// otherwise repeat the previous triple
			end
			send_triple(s, p, o, i == len - 1);
		end
	endtask

	initial begin
		int streams_done;
		streams_done = 0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first triple, new object, repeat, predicate and subject changes
		send_triple(32'd1, 32'd1, 32'd1, 1'b0);
		send_triple(32'd1, 32'd1, 32'hFFFFFFFF, 1'b0);
		send_triple(32'd1, 32'd1, 32'hFFFFFFFF, 1'b0);
		send_triple(32'd1, 32'hFFFFFFFF, 32'd2, 1'b0);
		send_triple(32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF, 1'b0);
		// unsorted subject change closing the stream: six words
		send_triple(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 1'b1);
		// zero object on the first triple of a new stream
		send_triple(32'd5, 32'd6, 32'd0, 1'b0);
		send_triple(32'd5, 32'd6, 32'd0, 1'b0);
		send_triple(32'd5, 32'd6, 32'd7, 1'b0);
		// zero IDs encoded as ordinary words
		send_triple(32'd0, 32'd6, 32'd7, 1'b0);
		send_triple(32'd0, 32'd0, 32'd7, 1'b0);
		send_triple(32'd0, 32'd0, 32'd0, 1'b0);
		// repeated triple that closes the stream
		send_triple(32'd0, 32'd0, 32'd0, 1'b1);
		// all-zero first triple that also closes its stream
		send_triple(32'd0, 32'd0, 32'd0, 1'b1);
		// single-triple stream
		send_triple(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 1'b1);
		send_triple(32'd3, 32'd3, 32'd3, 1'b0);
		send_triple(32'd3, 32'd3, 32'd3, 1'b0);
		send_triple(32'd3, 32'd3, 32'd4, 1'b1);
		// predicate going down, then a closing repeat
		send_triple(32'd2, 32'd9, 32'd9, 1'b0);
		send_triple(32'd2, 32'd8, 32'd9, 1'b0);
		send_triple(32'd2, 32'd8, 32'd9, 1'b1);

		// random streams, with quiet stretches on either side
		while (triples_sent < TOTAL_ITEMS) begin
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = ($urandom_range(0, 4) == 0);
			if (streams_done == 6) begin
				// hold the word channel off while triples keep coming
				hold_requests++;
				tx_quiet = 1'b1;
				run_random_stream(16);
			end else begin
				run_random_stream($urandom_range(1, 14));
			end
			streams_done++;
			if (streams_done == 12) begin
				// pause until every queued word has left
				@(negedge clk);
				triple_valid <= 1'b0;
				while (words_pending != 0) @(negedge clk);
			end
		end

		// drain and settle
		@(negedge clk);
		triple_valid <= 1'b0;
		while (words_pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("sorted_triple_adjacency_encoder regression: pass");
		else
			$display("sorted_triple_adjacency_encoder regression: fail");
		$finish;
	end

endmodule
